[src/ogs_pkg.sv]
// ----------------------------------------------------------------------------
// ogs_pkg
// Shared types, sizes and helpers for the occupancy grid obstacle stamper.
// ----------------------------------------------------------------------------
package ogs_pkg;

    localparam int GRID_X      = 200;
    localparam int GRID_Y      = 300;
    localparam int MAX_PATTERN = 64;
    localparam int ROW_OFFSET  = GRID_Y / 2;
    localparam int CELLS       = GRID_X * GRID_Y;

    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);
    localparam int COL_W   = $clog2(GRID_X);
    localparam int ROW_W   = $clog2(GRID_Y);
    localparam int PAT_W   = $clog2(MAX_PATTERN);
    localparam int COORD_W = 12;
    localparam int CODE_W  = 3;
    localparam int RAD_W   = 6;
    localparam int SIZE_W  = 7;

    // Reciprocal of ten in 16 fractional bits; exact for inputs up to 2048.
    localparam int RECIP10 = 6554;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [CODE_W-1:0] code_t;

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_STAMP_S = 3'd1,
        OP_STAMP_M = 3'd2,
        OP_FILL    = 3'd3,
        OP_SAVE    = 3'd4,
        OP_RESTORE = 3'd5,
        OP_READ    = 3'd6,
        OP_WRITE   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        REG_STATIC_RADIUS = 2'd0,
        REG_STATIC_SIZE   = 2'd1,
        REG_MOBILE_RADIUS = 2'd2,
        REG_MOBILE_SIZE   = 2'd3
    } cfg_reg_t;

    localparam code_t CODE_FREE        = 3'd0;
    localparam code_t CODE_STATIC_OBST = 3'd1;
    localparam code_t CODE_STATIC_EXCL = 3'd2;
    localparam code_t CODE_MOBILE_OBST = 3'd3;
    localparam code_t CODE_MOBILE_EXCL = 3'd4;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_COPY,
        ST_CENTRE,
        ST_PAT,
        ST_PAT_WR,
        ST_NEXT_CELL,
        ST_READ,
        ST_DONE
    } state_t;

    function automatic logic [8:0] div10(input logic [11:0] m);
        logic [24:0] p;
        p = {13'd0, m} * 25'(RECIP10);
        return p[24:16];
    endfunction

    function automatic coord_t mm_to_cm(input logic signed [11:0] v);
        logic [11:0] mag;
        coord_t      q;
        mag = v[11] ? 12'(-v) : v;
        q   = coord_t'({3'd0, div10(mag)});
        return v[11] ? coord_t'(-q) : q;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] c,
                                                    input logic [ROW_W-1:0] r);
        return ADDR_W'(int'(r) * GRID_X + int'(c));
    endfunction

endpackage

[src/occupancy_grid_obstacle_stamper.sv]
// ----------------------------------------------------------------------------
// occupancy_grid_obstacle_stamper
// Command engine over a centimetre occupancy grid with a static backup copy.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake         Contents
// s_        in   tvalid/tready     tuser: operation; tdata: coordinates, code
// m_        out  tvalid/tready     tdata: code_out, blocked, out_of_range
// cfg_      in   cfg_we            cfg_index, cfg_wdata
//
// After reset a clearing pass over every cell of both memories runs before the first item.
// A point stamp writes the centre, then visits each pattern cell (size squared) in turn.
// A rectangle repeats the point stamp for every cell, on the single grid port.
// Each item ends in a state that loads the output register once the output is free.
// ----------------------------------------------------------------------------
module occupancy_grid_obstacle_stamper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // operation
    input  logic [55:0] s_tdata,   // x_mm, y_mm, x2_mm, y2_mm, cell_code, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // code_out, blocked, out_of_range, zero fill
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_wdata
);

    localparam int AW = ogs_pkg::ADDR_W;
    localparam int CW = ogs_pkg::COL_W;
    localparam int RW = ogs_pkg::ROW_W;
    localparam int PW = ogs_pkg::PAT_W;

    ogs_pkg::state_t state_reg, state_next;
    logic [ogs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic copy_dir_reg, copy_dir_next;
    logic fill_reg, fill_next;
    logic [CW-1:0] cen_col_reg, cen_col_next, clo_reg, clo_next, clast_reg, clast_next;
    logic [RW-1:0] cen_row_reg, cen_row_next, rlast_reg, rlast_next;
    logic [PW-1:0] px_reg, px_next, py_reg, py_next;
    logic [PW:0] sz_reg, sz_next;
    logic [ogs_pkg::RAD_W-1:0] rad_reg, rad_next;
    ogs_pkg::code_t cen_code_reg, cen_code_next, excl_reg, excl_next;
    ogs_pkg::code_t code_reg, code_next;
    logic blk_reg, blk_next, oor_reg, oor_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_data_reg, m_data_next;

    logic [ogs_pkg::RAD_W-1:0] st_rad_reg, mb_rad_reg;
    logic [ogs_pkg::SIZE_W-1:0] st_size_reg, mb_size_reg;

    logic g_we, b_we;
    logic [AW-1:0] g_waddr, g_raddr, b_waddr, b_raddr;
    ogs_pkg::code_t g_wdata, b_wdata, g_rdata, b_rdata;

    ogs_pkg::op_t op;
    ogs_pkg::coord_t col1, row1, col2, row2, clo, chi, rlo, rhi, chi_c, rlo_c, rhi_c;
    ogs_pkg::coord_t ra, ca, half;
    logic in_grid, cell_ok, last_px, last_py;
    logic signed [7:0] dx, dy;
    logic [14:0] dist2;
    logic [11:0] rad2;
    logic [AW-1:0] pt_addr, cen_addr, pat_addr, cnt_addr;
    logic [PW:0] st_sz, mb_sz;

    assign op   = ogs_pkg::op_t'(s_tuser);
    assign col1 = ogs_pkg::mm_to_cm({1'b0, s_tdata[10:0]});
    assign row1 = ogs_pkg::mm_to_cm(s_tdata[22:11]) + ogs_pkg::coord_t'(ogs_pkg::ROW_OFFSET);
    assign col2 = ogs_pkg::mm_to_cm({1'b0, s_tdata[33:23]});
    assign row2 = ogs_pkg::mm_to_cm(s_tdata[45:34]) + ogs_pkg::coord_t'(ogs_pkg::ROW_OFFSET);

    assign in_grid = (col1 < ogs_pkg::coord_t'(ogs_pkg::GRID_X)) && (row1 >= 0)
                     && (row1 < ogs_pkg::coord_t'(ogs_pkg::GRID_Y));
    assign pt_addr = ogs_pkg::cell_addr(col1[CW-1:0], row1[RW-1:0]);

    assign clo   = (col1 < col2) ? col1 : col2;
    assign chi   = (col1 < col2) ? col2 : col1;
    assign rlo   = (row1 < row2) ? row1 : row2;
    assign rhi   = (row1 < row2) ? row2 : row1;
    assign chi_c = (chi > ogs_pkg::coord_t'(ogs_pkg::GRID_X))
                   ? ogs_pkg::coord_t'(ogs_pkg::GRID_X) : chi;
    assign rlo_c = (rlo < 0) ? '0 : rlo;
    assign rhi_c = (rhi > ogs_pkg::coord_t'(ogs_pkg::GRID_Y))
                   ? ogs_pkg::coord_t'(ogs_pkg::GRID_Y) : rhi;

    assign st_sz = (st_size_reg > ogs_pkg::SIZE_W'(ogs_pkg::MAX_PATTERN))
                   ? (PW+1)'(ogs_pkg::MAX_PATTERN) : (PW+1)'(st_size_reg);
    assign mb_sz = (mb_size_reg > ogs_pkg::SIZE_W'(ogs_pkg::MAX_PATTERN))
                   ? (PW+1)'(ogs_pkg::MAX_PATTERN) : (PW+1)'(mb_size_reg);

    assign cen_addr = ogs_pkg::cell_addr(cen_col_reg, cen_row_reg);
    assign half     = ogs_pkg::coord_t'(sz_reg >> 1);
    assign ra = ogs_pkg::coord_t'(cen_row_reg) - half + ogs_pkg::coord_t'(py_reg);
    assign ca = ogs_pkg::coord_t'(cen_col_reg) - half + ogs_pkg::coord_t'(px_reg);
    assign dx = $signed({2'b0, px_reg}) - $signed({2'b0, rad_reg});
    assign dy = $signed({2'b0, py_reg}) - $signed({2'b0, rad_reg});
    assign dist2 = 15'(dx * dx) + 15'(dy * dy);
    assign rad2  = 12'(rad_reg * rad_reg);
    assign cell_ok = (ra >= 1) && (ra <= ogs_pkg::coord_t'(ogs_pkg::GRID_Y - 2))
                     && (ca >= 1) && (ca <= ogs_pkg::coord_t'(ogs_pkg::GRID_X - 2))
                     && (dist2 < 15'(rad2));
    assign pat_addr = ogs_pkg::cell_addr(ca[CW-1:0], ra[RW-1:0]);
    assign last_px  = ({1'b0, px_reg} == sz_reg - 1'b1);
    assign last_py  = ({1'b0, py_reg} == sz_reg - 1'b1);
    assign cnt_addr = (cnt_reg < ogs_pkg::CNT_W'(ogs_pkg::CELLS)) ? cnt_reg[AW-1:0] : '0;

    ogs_ram #(.WIDTH(ogs_pkg::CODE_W), .DEPTH(ogs_pkg::CELLS)) u_grid (
        .aclk(aclk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );

    ogs_ram #(.WIDTH(ogs_pkg::CODE_W), .DEPTH(ogs_pkg::CELLS)) u_backup (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ogs_pkg::ST_INIT;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            st_rad_reg   <= ogs_pkg::RAD_W'(15);
            st_size_reg  <= ogs_pkg::SIZE_W'(31);
            mb_rad_reg   <= ogs_pkg::RAD_W'(25);
            mb_size_reg  <= ogs_pkg::SIZE_W'(51);
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                unique case (ogs_pkg::cfg_reg_t'(cfg_index))
                    ogs_pkg::REG_STATIC_RADIUS: st_rad_reg  <= cfg_wdata[5:0];
                    ogs_pkg::REG_STATIC_SIZE:   st_size_reg <= cfg_wdata;
                    ogs_pkg::REG_MOBILE_RADIUS: mb_rad_reg  <= cfg_wdata[5:0];
                    ogs_pkg::REG_MOBILE_SIZE:   mb_size_reg <= cfg_wdata;
                endcase
            end
        end
        copy_dir_reg <= copy_dir_next;
        fill_reg     <= fill_next;
        cen_col_reg  <= cen_col_next;
        cen_row_reg  <= cen_row_next;
        clo_reg      <= clo_next;
        clast_reg    <= clast_next;
        rlast_reg    <= rlast_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        sz_reg       <= sz_next;
        rad_reg      <= rad_next;
        cen_code_reg <= cen_code_next;
        excl_reg     <= excl_next;
        code_reg     <= code_next;
        blk_reg      <= blk_next;
        oor_reg      <= oor_next;
        m_data_reg   <= m_data_next;
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        copy_dir_next = copy_dir_reg;
        fill_next     = fill_reg;
        cen_col_next  = cen_col_reg;
        cen_row_next  = cen_row_reg;
        clo_next      = clo_reg;
        clast_next    = clast_reg;
        rlast_next    = rlast_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        sz_next       = sz_reg;
        rad_next      = rad_reg;
        cen_code_next = cen_code_reg;
        excl_next     = excl_reg;
        code_next     = code_reg;
        blk_next      = blk_reg;
        oor_next      = oor_reg;
        m_data_next   = m_data_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        g_we    = 1'b0;
        g_waddr = cnt_addr;
        g_wdata = ogs_pkg::CODE_FREE;
        g_raddr = cnt_addr;
        b_we    = 1'b0;
        b_waddr = cnt_addr;
        b_wdata = ogs_pkg::CODE_FREE;
        b_raddr = cnt_addr;

        unique case (state_reg)
            ogs_pkg::ST_INIT: begin
                g_we = 1'b1;
                b_we = 1'b1;
                if (cnt_reg == ogs_pkg::CNT_W'(ogs_pkg::CELLS - 1)) begin
                    cnt_next   = '0;
                    state_next = ogs_pkg::ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ogs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    oor_next   = 1'b0;
                    code_next  = ogs_pkg::CODE_FREE;
                    blk_next   = 1'b0;
                    fill_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = ogs_pkg::ST_DONE;
                    cen_col_next = col1[CW-1:0];
                    cen_row_next = row1[RW-1:0];
                    unique case (op)
                        ogs_pkg::OP_CLEAR: state_next = ogs_pkg::ST_CLEAR;
                        ogs_pkg::OP_STAMP_S, ogs_pkg::OP_STAMP_M: begin
                            if (!in_grid) begin
                                oor_next = 1'b1;
                            end else begin
                                state_next = ogs_pkg::ST_CENTRE;
                                if (op == ogs_pkg::OP_STAMP_S) begin
                                    cen_code_next = ogs_pkg::CODE_STATIC_OBST;
                                    excl_next     = ogs_pkg::CODE_STATIC_EXCL;
                                    rad_next      = st_rad_reg;
                                    sz_next       = st_sz;
                                end else begin
                                    cen_code_next = ogs_pkg::CODE_MOBILE_OBST;
                                    excl_next     = ogs_pkg::CODE_MOBILE_EXCL;
                                    rad_next      = mb_rad_reg;
                                    sz_next       = mb_sz;
                                end
                            end
                        end
                        ogs_pkg::OP_FILL: begin
                            oor_next = (clo < chi) && (rlo < rhi)
                                       && ((chi > ogs_pkg::coord_t'(ogs_pkg::GRID_X))
                                       || (rlo < 0)
                                       || (rhi > ogs_pkg::coord_t'(ogs_pkg::GRID_Y)));
                            cen_col_next  = clo[CW-1:0];
                            cen_row_next  = rlo_c[RW-1:0];
                            clo_next      = clo[CW-1:0];
                            clast_next    = CW'(chi_c - 1);
                            rlast_next    = RW'(rhi_c - 1);
                            cen_code_next = ogs_pkg::CODE_STATIC_OBST;
                            excl_next     = ogs_pkg::CODE_STATIC_EXCL;
                            rad_next      = st_rad_reg;
                            sz_next       = st_sz;
                            fill_next     = 1'b1;
                            if ((clo < chi_c) && (rlo_c < rhi_c)) begin
                                state_next = ogs_pkg::ST_CENTRE;
                            end
                        end
                        ogs_pkg::OP_SAVE, ogs_pkg::OP_RESTORE: begin
                            copy_dir_next = (op == ogs_pkg::OP_RESTORE);
                            state_next    = ogs_pkg::ST_COPY;
                        end
                        ogs_pkg::OP_READ: begin
                            g_raddr = pt_addr;
                            if (in_grid) begin
                                state_next = ogs_pkg::ST_READ;
                            end else begin
                                oor_next = 1'b1;
                            end
                        end
                        ogs_pkg::OP_WRITE: begin
                            g_waddr = pt_addr;
                            g_wdata = s_tdata[48:46];
                            g_we    = in_grid;
                            oor_next = !in_grid;
                        end
                    endcase
                end
            end
            ogs_pkg::ST_CLEAR: begin
                g_we = 1'b1;
                if (cnt_reg == ogs_pkg::CNT_W'(ogs_pkg::CELLS - 1)) begin
                    state_next = ogs_pkg::ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ogs_pkg::ST_COPY: begin
                g_waddr = AW'(cnt_reg - 1'b1);
                b_waddr = AW'(cnt_reg - 1'b1);
                g_wdata = b_rdata;
                b_wdata = g_rdata;
                g_we = copy_dir_reg && (cnt_reg != '0);
                b_we = !copy_dir_reg && (cnt_reg != '0);
                if (cnt_reg == ogs_pkg::CNT_W'(ogs_pkg::CELLS)) begin
                    state_next = ogs_pkg::ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ogs_pkg::ST_CENTRE: begin
                g_we    = 1'b1;
                g_waddr = cen_addr;
                g_wdata = cen_code_reg;
                px_next = '0;
                py_next = '0;
                state_next = (sz_reg == '0) ? ogs_pkg::ST_NEXT_CELL : ogs_pkg::ST_PAT;
            end
            ogs_pkg::ST_PAT, ogs_pkg::ST_PAT_WR: begin
                g_raddr = pat_addr;
                g_waddr = pat_addr;
                g_wdata = excl_reg;
                if ((state_reg == ogs_pkg::ST_PAT) && cell_ok) begin
                    state_next = ogs_pkg::ST_PAT_WR;
                end else begin
                    g_we       = (state_reg == ogs_pkg::ST_PAT_WR)
                                 && (g_rdata == ogs_pkg::CODE_FREE);
                    state_next = ogs_pkg::ST_PAT;
                    if (last_px) begin
                        px_next = '0;
                        if (last_py) begin
                            state_next = ogs_pkg::ST_NEXT_CELL;
                        end else begin
                            py_next = py_reg + 1'b1;
                        end
                    end else begin
                        px_next = px_reg + 1'b1;
                    end
                end
            end
            ogs_pkg::ST_NEXT_CELL: begin
                state_next = ogs_pkg::ST_CENTRE;
                if (!fill_reg) begin
                    state_next = ogs_pkg::ST_DONE;
                end else if (cen_col_reg == clast_reg) begin
                    cen_col_next = clo_reg;
                    if (cen_row_reg == rlast_reg) begin
                        state_next = ogs_pkg::ST_DONE;
                    end else begin
                        cen_row_next = cen_row_reg + 1'b1;
                    end
                end else begin
                    cen_col_next = cen_col_reg + 1'b1;
                end
            end
            ogs_pkg::ST_READ: begin
                code_next  = g_rdata;
                blk_next   = (g_rdata >= ogs_pkg::CODE_STATIC_OBST)
                             && (g_rdata <= ogs_pkg::CODE_MOBILE_EXCL);
                state_next = ogs_pkg::ST_DONE;
            end
            ogs_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {3'd0, oor_reg, blk_reg, code_reg};
                    state_next    = ogs_pkg::ST_IDLE;
                end
            end
            default: state_next = ogs_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    a_both_we_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (g_we && b_we) |-> (state_reg == ogs_pkg::ST_INIT))
        else $error("both memories written outside the clearing pass");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ogs_pkg::ST_IDLE) && !s_tvalid) |-> (!g_we && !b_we))
        else $error("memory written while idle");

    a_px_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ogs_pkg::ST_PAT) |-> ({1'b0, px_reg} < sz_reg))
        else $error("pattern column beyond pattern size");

    a_blocked_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> ((m_tdata[2:0] >= ogs_pkg::CODE_STATIC_OBST)
        && (m_tdata[2:0] <= ogs_pkg::CODE_MOBILE_EXCL)))
        else $error("blocked flag with a non-blocking code");

    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ogs_pkg::ST_DONE) && (!m_tvalid_reg || m_tready)) |=> m_tvalid)
        else $error("finished item not presented");

endmodule

[src/ogs_ram.sv]
// ----------------------------------------------------------------------------
// ogs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ogs_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 60000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
